/* sv/assert_macros.svh */
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define LFC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition that must never be seen outside reset.
`define LFC_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

/* sv/lfc_pkg.sv */
package lfc_pkg;

  localparam int KIND_W    = 2;
  localparam int TAP_IDX_W = 12;
  localparam int TAP_CNT_W = 13;
  // widest sample or coefficient word carried through the command queue
  localparam int WORD_W    = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_LOAD   = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [WORD_W-1:0]     data;
    logic [TAP_IDX_W-1:0]  idx;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_ROUND
  } state_t;

endpackage

/* sv/lfc_if.sv */
interface lfc_in_if import lfc_pkg::*; #(
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 24
);
  logic                         valid;
  logic                         ready;
  logic [KIND_W-1:0]            kind;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic [TAP_IDX_W-1:0]         tap_index;
  logic signed [COEF_BITS-1:0]  tap_value;

  modport source (output valid, kind, sample_in, tap_index, tap_value, input ready);
  modport sink   (input valid, kind, sample_in, tap_index, tap_value, output ready);
endinterface

interface lfc_out_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          clipped;

  modport source (output valid, sample_out, clipped, input ready);
  modport sink   (input valid, sample_out, clipped, output ready);
endinterface

/* sv/lfc_ram.sv */
module lfc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;
endmodule

/* sv/lfc_front.sv */
module lfc_front import lfc_pkg::*; (
  lfc_in_if.sink    in_ch,
  output logic      push_valid,
  input  logic      push_ready,
  output cmd_t      push_cmd
);
  // unknown kinds are taken and dropped here
  assign in_ch.ready = push_ready;

  always_comb begin
    push_valid    = 1'b0;
    push_cmd.kind = KIND_SAMPLE;
    push_cmd.data = '0;
    push_cmd.idx  = in_ch.tap_index;
    case (in_ch.kind)
      KIND_SAMPLE: begin
        push_valid    = in_ch.valid;
        push_cmd.kind = KIND_SAMPLE;
        push_cmd.data = WORD_W'(unsigned'(in_ch.sample_in));
      end
      KIND_LOAD: begin
        push_valid    = in_ch.valid;
        push_cmd.kind = KIND_LOAD;
        push_cmd.data = WORD_W'(unsigned'(in_ch.tap_value));
      end
      KIND_CLEAR: begin
        push_valid    = in_ch.valid;
        push_cmd.kind = KIND_CLEAR;
      end
      default: begin
        push_valid = 1'b0;
      end
    endcase
  end
endmodule

/* sv/lfc_cmd_fifo.sv */
module lfc_cmd_fifo import lfc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);
  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);

  cmd_t              entries_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]   count_r, count_nxt;
  logic              push, pop;

  assign push_ready = (count_r != CNTW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = entries_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r + CNTW'(push) - CNTW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end
endmodule

/* sv/lfc_back.sv */
`include "assert_macros.svh"

module lfc_back import lfc_pkg::*; #(
  parameter int MAX_TAPS    = 4096,
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  cmd_t                  cmd,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [TAP_CNT_W-1:0]  cfg_tap_count,
  lfc_out_if.source             out_ch
);
  localparam int AW     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CW     = $clog2(MAX_TAPS + 1);
  localparam int PW     = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W  = PW + CW + 1;
  localparam int RND_SH = COEF_BITS - 1;
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (COEF_BITS - 2);
  localparam logic signed [ACC_W-1:0] OUT_MAX  =
      (ACC_W'(1) << (SAMPLE_BITS - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] OUT_MIN  = ~OUT_MAX;
  localparam logic [AW-1:0] LAST_POS = AW'(MAX_TAPS - 1);
  localparam logic [CW-1:0] TAPS_CW  = CW'(MAX_TAPS);

  state_t                   state_r, state_nxt;
  logic [TAP_CNT_W-1:0]     tap_cnt_r;
  logic [AW-1:0]            wp_r, wp_nxt;
  logic [CW-1:0]            fill_r, fill_nxt;
  logic [CW-1:0]            rem_r, rem_nxt;
  logic [AW-1:0]            k_r, k_nxt;
  logic [AW-1:0]            pos_r, pos_nxt;
  logic                     rd_v_r, prod_v_r;
  logic signed [PW-1:0]     prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     out_valid_r;
  logic [SAMPLE_BITS-1:0]   out_sample_r;
  logic                     out_clip_r;

  logic [CW-1:0]            n_taps, fill_inc, run_len;
  logic                     tap_we, hist_we, acc_clr, out_load, issue;
  logic [COEF_BITS-1:0]     tap_rd;
  logic [SAMPLE_BITS-1:0]   hist_rd;
  logic signed [COEF_BITS-1:0]   tap_rd_s;
  logic signed [SAMPLE_BITS-1:0] hist_rd_s;
  logic signed [ACC_W-1:0]  biased, shifted;
  logic                     over, under;
  logic [SAMPLE_BITS-1:0]   rnd_val;

  lfc_ram #(.WIDTH(COEF_BITS), .DEPTH(MAX_TAPS)) u_tap_ram (
    .clk     (clk),
    .wr_en   (tap_we),
    .wr_addr (AW'(cmd.idx)),
    .wr_data (cmd.data[COEF_BITS-1:0]),
    .rd_addr (k_r),
    .rd_data (tap_rd)
  );

  lfc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_hist_ram (
    .clk     (clk),
    .wr_en   (hist_we),
    .wr_addr (wp_r),
    .wr_data (cmd.data[SAMPLE_BITS-1:0]),
    .rd_addr (pos_r),
    .rd_data (hist_rd)
  );

  assign cfg_ready = 1'b1;
  assign tap_rd_s  = tap_rd;
  assign hist_rd_s = hist_rd;
  assign issue     = (state_r == ST_RUN);

  // History slots not written since the last clear are never read: the
  // tap loop stops at the number of samples seen since then.
  always_comb begin
    n_taps   = (32'(tap_cnt_r) > MAX_TAPS) ? TAPS_CW : CW'(tap_cnt_r);
    fill_inc = (fill_r == TAPS_CW) ? fill_r : fill_r + CW'(1);
    run_len  = (n_taps < fill_inc) ? n_taps : fill_inc;
  end

  always_comb begin
    state_nxt = state_r;
    cmd_ready = 1'b0;
    tap_we    = 1'b0;
    hist_we   = 1'b0;
    acc_clr   = 1'b0;
    out_load  = 1'b0;
    wp_nxt    = wp_r;
    fill_nxt  = fill_r;
    rem_nxt   = rem_r;
    k_nxt     = k_r;
    pos_nxt   = pos_r;
    case (state_r)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          case (cmd.kind)
            KIND_LOAD: begin
              tap_we = (32'(cmd.idx) < MAX_TAPS);
            end
            KIND_CLEAR: begin
              wp_nxt   = '0;
              fill_nxt = '0;
            end
            KIND_SAMPLE: begin
              hist_we   = 1'b1;
              fill_nxt  = fill_inc;
              wp_nxt    = (wp_r == LAST_POS) ? '0 : wp_r + AW'(1);
              pos_nxt   = wp_r;
              k_nxt     = '0;
              rem_nxt   = run_len;
              acc_clr   = 1'b1;
              state_nxt = (run_len == '0) ? ST_DRAIN : ST_RUN;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_RUN: begin
        rem_nxt = rem_r - CW'(1);
        k_nxt   = k_r + AW'(1);
        pos_nxt = (pos_r == '0) ? LAST_POS : pos_r - AW'(1);
        if (rem_r == CW'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_v_r && !prod_v_r) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // round half up, drop the fraction, saturate
  always_comb begin
    biased  = acc_r + RND_HALF;
    shifted = biased >>> RND_SH;
    over    = (shifted > OUT_MAX);
    under   = (shifted < OUT_MIN);
    if (over) begin
      rnd_val = OUT_MAX[SAMPLE_BITS-1:0];
    end else if (under) begin
      rnd_val = OUT_MIN[SAMPLE_BITS-1:0];
    end else begin
      rnd_val = shifted[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tap_cnt_r   <= '0;
      wp_r        <= '0;
      fill_r      <= '0;
      rem_r       <= '0;
      k_r         <= '0;
      pos_r       <= '0;
      rd_v_r      <= 1'b0;
      prod_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wp_r     <= wp_nxt;
      fill_r   <= fill_nxt;
      rem_r    <= rem_nxt;
      k_r      <= k_nxt;
      pos_r    <= pos_nxt;
      rd_v_r   <= issue;
      prod_v_r <= rd_v_r;
      if (cfg_valid) begin
        tap_cnt_r <= cfg_tap_count;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= tap_rd_s * hist_rd_s;
    if (acc_clr) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + {{(ACC_W - PW){prod_r[PW-1]}}, prod_r};
    end
    if (out_load) begin
      out_sample_r <= rnd_val;
      out_clip_r   <= over || under;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_sample_r;
  assign out_ch.clipped    = out_clip_r;

  `LFC_ASSERT(a_run_has_work, clk, rst_n, (state_r == ST_RUN) |-> (rem_r != '0), "tap loop running with nothing left")
  `LFC_NEVER(a_round_drained, clk, rst_n, (state_r == ST_ROUND) && (rd_v_r || prod_v_r), "rounding before MAC pipe drained")
  `LFC_NEVER(a_fill_bound, clk, rst_n, fill_r > TAPS_CW, "history fill count beyond depth")
  `LFC_NEVER(a_wp_bound, clk, rst_n, 32'(wp_r) >= MAX_TAPS, "write position beyond depth")
  `LFC_ASSERT(a_result_posted, clk, rst_n, out_load |=> (out_ch.valid && (state_r == ST_IDLE)), "result not posted after rounding")
endmodule

/* sv/long_fir_convolver_top.sv */
// Long FIR convolver: each audio sample request returns one Q1.23 output,
// the exact sum over taps k below tap_count of tap[k] times the sample k
// requests back, rounded half up and saturated, with clipped set on
// saturation. Coefficient and clear requests return nothing. A sample's
// tap loop covers min(tap_count, samples since the last clear or reset)
// taps through the single multiply-accumulate unit, which walks the taps
// one per cycle through one read port each on the tap and history RAMs;
// the result may then wait for the output register to free. A two-entry
// command queue lets the input keep taking requests while a sample is
// being worked on, and a finished result waits in an output register.
// History needs no clearing pass: slots older than the last clear are
// never read. Load every tap below tap_count before sending samples;
// write tap_count only while idle.
module long_fir_convolver_top import lfc_pkg::*; #(
  parameter int MAX_TAPS    = 4096,
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  lfc_in_if.sink               in_ch,
  lfc_out_if.source            out_ch,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [TAP_CNT_W-1:0] cfg_tap_count
);
  logic push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_cmd, pop_cmd;

  lfc_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  lfc_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  lfc_back #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (pop_valid),
    .cmd_ready     (pop_ready),
    .cmd           (pop_cmd),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_tap_count (cfg_tap_count),
    .out_ch        (out_ch)
  );
endmodule
